[design/ipst_pkg.sv]
// Shared types and operation codes for the IP address set table.
package ipst_pkg;

   localparam int SET_DEPTH_DEFAULT = 16;

   localparam logic [2:0] OP_LOOKUP        = 3'd0;
   localparam logic [2:0] OP_ADD           = 3'd1;
   localparam logic [2:0] OP_ADD_UNCHECKED = 3'd2;
   localparam logic [2:0] OP_DELETE        = 3'd3;
   localparam logic [2:0] OP_PURGE         = 3'd4;
   localparam logic [2:0] OP_QUERY         = 3'd5;

   typedef struct packed {
      logic [2:0]  operation;
      logic        family_is_v6;
      logic [63:0] address_high;
      logic [63:0] address_low;
      logic [31:0] interface_index;
      logic [7:0]  prefix_length;
   } req_type;

   typedef struct packed {
      logic       hit;
      logic       table_full;
      logic [4:0] entry_total;
   } rsp_type;

   typedef struct packed {
      logic        family_is_v6;
      logic [63:0] addr_high;
      logic [63:0] addr_low;
      logic [31:0] ifindex;
   } entry_type;

endpackage

[design/ipst_compare.sv]
// Entry comparator: exact match and prefix containment against the search key.
module ipst_compare (
   input  ipst_pkg::entry_type entry,
   input  ipst_pkg::entry_type key,
   input  logic [63:0]         mask_hi,
   input  logic [63:0]         mask_lo,
   output logic                equal,
   output logic                in_net
);
   import ipst_pkg::*;

   logic fam_eq;

   assign fam_eq = (entry.family_is_v6 == key.family_is_v6);

   assign equal = fam_eq && (entry.addr_high == key.addr_high) &&
                  (entry.addr_low == key.addr_low) && (entry.ifindex == key.ifindex);

   // interface index plays no part in the network test
   assign in_net = fam_eq &&
                   ((((entry.addr_high ^ key.addr_high) & mask_hi) |
                     ((entry.addr_low ^ key.addr_low) & mask_lo)) == 64'd0);

endmodule

[design/ip_address_set_table.sv]
// Top level of the IP address set table: control sequencer around the entry memory.
// Lookup, add, delete and query scan the stored entries in order and stop at the first match;
//   a delete that hits then shifts the entries above the match down one place.
// Throughput: one item at a time; a new request is taken once the block is back in idle,
//   as its result is raised; the scan and shift walk the memory at one entry a cycle.
// Add unchecked, purge and unused codes skip the scan. Reset clears control and count, not memory.
module ip_address_set_table #(
   parameter int SET_DEPTH = ipst_pkg::SET_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ipst_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ipst_pkg::rsp_type rsp_data
);
   import ipst_pkg::*;

   // count holds 0..SET_DEPTH, index holds 0..SET_DEPTH-1
   localparam int CW = $clog2(SET_DEPTH + 1);
   localparam int IW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_SHIFT = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [2:0]    op_ff, op_in;
   entry_type     key_ff, key_in;
   logic [63:0]   mask_hi_ff, mask_hi_in;
   logic [63:0]   mask_lo_ff, mask_lo_in;
   logic          found_ff, found_in;
   logic [CW-1:0] issue_ff, issue_in;
   logic          rd_vld_ff, rd_vld_in;
   logic [IW-1:0] rd_idx_ff, rd_idx_in;
   logic [CW-1:0] count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   // entry memory: one read port, one write port, registered read data
   entry_type     mem [SET_DEPTH];
   entry_type     rd_data_ff;
   logic          rd_en;
   logic [IW-1:0] rd_addr;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   entry_type     wr_data;

   logic          cmp_equal;
   logic          cmp_in_net;
   logic          hit_now;

   ipst_compare u_compare (
      .entry   (rd_data_ff),
      .key     (key_ff),
      .mask_hi (mask_hi_ff),
      .mask_lo (mask_lo_ff),
      .equal   (cmp_equal),
      .in_net  (cmp_in_net)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a scan match: prefix containment for the query, exact match otherwise
   assign hit_now = rd_vld_ff && ((op_ff == OP_QUERY) ? cmp_in_net : cmp_equal);

   always_comb begin
      logic [7:0]   plen6;
      logic [5:0]   plen4;
      logic [127:0] mask6;
      logic [31:0]  mask4;

      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      mask_hi_in   = mask_hi_ff;
      mask_lo_in   = mask_lo_ff;
      found_in     = found_ff;
      issue_in     = issue_ff;
      rd_vld_in    = rd_vld_ff;
      rd_idx_in    = rd_idx_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rd_en        = 1'b0;
      rd_addr      = issue_ff[IW-1:0];
      wr_en        = 1'b0;
      wr_addr      = rd_idx_ff - IW'(1);
      wr_data      = rd_data_ff;

      // prefix masks, long prefixes clamped; zero length gives an empty mask, so any address of the family matches
      plen6 = (req_data.prefix_length > 8'd128) ? 8'd128 : req_data.prefix_length;
      plen4 = (req_data.prefix_length > 8'd32) ? 6'd32 : req_data.prefix_length[5:0];
      mask6 = (plen6 == 8'd0) ? 128'd0 : ({128{1'b1}} << (8'd128 - plen6));
      mask4 = (plen4 == 6'd0) ? 32'd0 : (32'hffffffff << (6'd32 - plen4));

      // result register drains independently of the sequencer
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in                = req_data.operation;
               key_in.family_is_v6  = req_data.family_is_v6;
               key_in.ifindex       = req_data.interface_index;
               // IPv4 keeps only the low 32 bits; upper bits read as zero
               if (req_data.family_is_v6) begin
                  key_in.addr_high = req_data.address_high;
                  key_in.addr_low  = req_data.address_low;
                  mask_hi_in       = mask6[127:64];
                  mask_lo_in       = mask6[63:0];
               end else begin
                  key_in.addr_high = 64'd0;
                  key_in.addr_low  = {32'd0, req_data.address_low[31:0]};
                  mask_hi_in       = 64'd0;
                  mask_lo_in       = {32'd0, mask4};
               end
               found_in  = 1'b0;
               issue_in  = '0;
               rd_vld_in = 1'b0;
               case (req_data.operation) inside
                  OP_LOOKUP, OP_ADD, OP_DELETE, OP_QUERY: state_in = S_SCAN;
                  default:                                state_in = S_DONE;
               endcase
            end
         end
         S_SCAN: begin
            rd_vld_in = 1'b0;
            if (issue_ff < count_ff) begin
               rd_en     = 1'b1;
               rd_vld_in = 1'b1;
               rd_idx_in = issue_ff[IW-1:0];
               issue_in  = issue_ff + CW'(1);
            end
            if (hit_now) begin
               found_in  = 1'b1;
               rd_vld_in = 1'b0;
               if (op_ff == OP_DELETE) begin
                  // compact: entries above the hit move down one place
                  issue_in = CW'(rd_idx_ff) + CW'(1);
                  state_in = S_SHIFT;
               end else begin
                  state_in = S_DONE;
               end
            end else if (!rd_vld_ff && (issue_ff >= count_ff)) begin
               state_in = S_DONE;
            end
         end
         S_SHIFT: begin
            // read i while writing i-2's successor to i-2; never the same entry
            rd_vld_in = 1'b0;
            if (issue_ff < count_ff) begin
               rd_en     = 1'b1;
               rd_vld_in = 1'b1;
               rd_idx_in = issue_ff[IW-1:0];
               issue_in  = issue_ff + CW'(1);
            end
            if (rd_vld_ff) begin
               wr_en = 1'b1;
            end
            if (!rd_vld_ff && (issue_ff >= count_ff)) begin
               count_in = count_ff - CW'(1);
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in               = S_IDLE;
               rsp_valid_in           = 1'b1;
               rsp_data_in.hit        = 1'b0;
               rsp_data_in.table_full = 1'b0;
               case (op_ff) inside
                  OP_LOOKUP, OP_QUERY, OP_DELETE: begin
                     rsp_data_in.hit = found_ff;
                  end
                  OP_ADD, OP_ADD_UNCHECKED: begin
                     // a duplicate on checked add does nothing, full or not
                     if (!found_ff) begin
                        if (count_ff == CW'(SET_DEPTH)) begin
                           rsp_data_in.table_full = 1'b1;
                        end else begin
                           wr_en           = 1'b1;
                           wr_addr         = count_ff[IW-1:0];
                           wr_data         = key_ff;
                           count_in        = count_ff + CW'(1);
                           rsp_data_in.hit = 1'b1;
                        end
                     end
                  end
                  OP_PURGE: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
               rsp_data_in.entry_total = 5'(count_in);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= rd_vld_in;
         found_ff     <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      mask_hi_ff  <= mask_hi_in;
      mask_lo_ff  <= mask_lo_in;
      issue_ff    <= issue_in;
      rd_idx_ff   <= rd_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(SET_DEPTH))
      else $error("entry count above table depth");

   a_write_state: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_SHIFT || state_ff == S_DONE))
      else $error("memory write outside shift or completion");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (CW'(wr_addr) < count_ff || (state_ff == S_DONE && CW'(wr_addr) == count_ff)))
      else $error("memory write beyond stored entries");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result raised outside completion");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |=> ($stable(op_ff) || $past(state_ff) == S_IDLE))
      else $error("operation changed while busy");
`endif

endmodule

[sim/ipst_table_checker.sv]
// Checker for the IP address set table: tracks table contents and scores every result transfer.
module ipst_table_checker #(
   parameter int SET_DEPTH = ipst_pkg::SET_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  ipst_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  ipst_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending_count,
   output int                result_count,
   output int                hit_count,
   output int                full_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import ipst_pkg::*;

   entry_type addr_set [SET_DEPTH];
   int        set_count;
   rsp_type   expected_rsp [$];

   // Applies one request to the shadow table and returns the result it should produce.
   function automatic rsp_type apply_op(req_type r);
      entry_type    key;
      rsp_type      res;
      int           pos;
      int           plen;
      logic [127:0] mask;
      logic [127:0] diff;
      key.family_is_v6 = r.family_is_v6;
      key.addr_high    = r.family_is_v6 ? r.address_high : 64'd0;
      key.addr_low     = r.family_is_v6 ? r.address_low : {32'd0, r.address_low[31:0]};
      key.ifindex      = r.interface_index;
      res = '0;
      pos = -1;
      for (int i = 0; i < set_count; i++) begin
         if (pos < 0 && addr_set[i] == key) pos = i;
      end
      case (r.operation)
         OP_LOOKUP: begin
            res.hit = (pos >= 0);
         end
         OP_ADD, OP_ADD_UNCHECKED: begin
            if (r.operation == OP_ADD_UNCHECKED || pos < 0) begin
               if (set_count < SET_DEPTH) begin
                  addr_set[set_count] = key;
                  set_count++;
                  res.hit = 1'b1;
               end else begin
                  res.table_full = 1'b1;
               end
            end
         end
         OP_DELETE: begin
            if (pos >= 0) begin
               for (int i = pos; i + 1 < set_count; i++) addr_set[i] = addr_set[i + 1];
               set_count--;
               res.hit = 1'b1;
            end
         end
         OP_PURGE: begin
            set_count = 0;
         end
         OP_QUERY: begin
            // interface index is ignored; prefix clamps to the family width
            if (r.family_is_v6) begin
               plen = (r.prefix_length > 8'd128) ? 128 : int'(r.prefix_length);
               mask = (plen == 0) ? '0 : (~128'd0 << (128 - plen));
            end else begin
               plen = (r.prefix_length > 8'd32) ? 32 : int'(r.prefix_length);
               mask = (plen == 0) ? '0 : {96'd0, 32'hffff_ffff << (32 - plen)};
            end
            for (int i = 0; i < set_count; i++) begin
               diff = {addr_set[i].addr_high, addr_set[i].addr_low} ^
                      {key.addr_high, key.addr_low};
               if (addr_set[i].family_is_v6 == key.family_is_v6 && (diff & mask) == '0)
                  res.hit = 1'b1;
            end
         end
         default: ;
      endcase
      res.entry_total = set_count[4:0];
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         set_count = 0;
         expected_rsp.delete();
      end else begin
         if (req_valid && !req_stall) expected_rsp.push_back(apply_op(req_data));
         if (rsp_valid && !rsp_stall) begin
            result_count++;
            if (expected_rsp.size() == 0) begin
               $error("result transfer with no request outstanding: %p", rsp_data);
               fail_count++;
            end else begin
               want = expected_rsp.pop_front();
               hit_count  += want.hit;
               full_count += want.table_full;
               if (rsp_data.hit !== want.hit) begin
                  $error("hit: expected %0d, got %0d", want.hit, rsp_data.hit);
                  fail_count++;
               end
               if (rsp_data.table_full !== want.table_full) begin
                  $error("table_full: expected %0d, got %0d", want.table_full,
                         rsp_data.table_full);
                  fail_count++;
               end
               if (rsp_data.entry_total !== want.entry_total) begin
                  $error("entry_total: expected %0d, got %0d", want.entry_total,
                         rsp_data.entry_total);
                  fail_count++;
               end
            end
         end
      end
      pending_count = expected_rsp.size();
   end

endmodule

[sim/tb_ip_address_set_table.sv]
// Testbench top for the IP address set table: stimulus, flow control and verdict.
module tb_ip_address_set_table;
   timeunit 1ns;
   timeprecision 1ps;

   import ipst_pkg::*;

   localparam int SET_DEPTH    = 16;
   localparam int ITEM_TOTAL   = 1800;
   localparam int CALM_TAIL    = 200;   // last transfers run with no idling at all
   localparam int POOL_SIZE    = 20;
   localparam int LONG_HOLD    = 400;   // receiver hold-off, in cycles
   localparam int DRAIN_CYCLES = 2 * SET_DEPTH + 12;
   localparam int FILL_ADDS    = 18;    // two more than fit, to hit the full table

   // codes the block must treat as no-ops
   localparam logic [2:0] OP_UNUSED_6 = 3'd6;
   localparam logic [2:0] OP_UNUSED_7 = 3'd7;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    rsp_stall = 1'b0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;

   int fail_count;
   int pending_count;
   int result_count;
   int hit_count;
   int full_count;

   // idle_on and long_hold_due pass from the sender to the receiver; long_hold_done is the receiver's own
   bit idle_on        = 1'b1;
   bit long_hold_due  = 1'b0;
   bit long_hold_done = 1'b0;

   entry_type pool [POOL_SIZE];
   req_type   stimulus [$];
   int        directed_total;

   ip_address_set_table #(
      .SET_DEPTH(SET_DEPTH)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   ipst_table_checker #(
      .SET_DEPTH(SET_DEPTH)
   ) i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .fail_count   (fail_count),
      .pending_count(pending_count),
      .result_count (result_count),
      .hit_count    (hit_count),
      .full_count   (full_count)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic req_type make_req(logic [2:0] op, entry_type e, logic [7:0] plen);
      req_type r;
      r.operation       = op;
      r.family_is_v6    = e.family_is_v6;
      r.address_high    = e.addr_high;
      r.address_low     = e.addr_low;
      r.interface_index = e.ifindex;
      r.prefix_length   = plen;
      return r;
   endfunction

   function automatic entry_type random_entry();
      entry_type e;
      e.family_is_v6 = 1'($urandom_range(0, 1));
      e.addr_high    = {$urandom, $urandom};
      e.addr_low     = {$urandom, $urandom};
      e.ifindex      = $urandom;
      return e;
   endfunction

   // Sender: builds the whole item list, then offers it one transfer at a time.
   initial begin
      entry_type    ent_a;
      entry_type    ent_a_alias;
      entry_type    ent_b;
      entry_type    ent_c;
      entry_type    e;
      entry_type    fresh [FILL_ADDS];
      logic [127:0] flat;
      logic [2:0]   op;
      logic [7:0]   plen;
      int           roll;
      int           pos;

      // ---- directed part ----
      // IPv4 entry with junk in the bits that normalization must drop
      ent_a       = '{1'b0, 64'hdead_beef_0123_4567, 64'hffff_ffff_c0a8_0101, 32'd2};
      ent_a_alias = '{1'b0, 64'h0bad_f00d_0000_0001, 64'h1234_5678_c0a8_0101, 32'd2};
      ent_b       = '{1'b1, '1, '1, 32'hffff_ffff};
      ent_c       = '{1'b1, 64'd0, 64'd0, 32'd0};

      stimulus.push_back(make_req(OP_LOOKUP, ent_a, 8'd0));         // empty table
      stimulus.push_back(make_req(OP_QUERY, ent_a, 8'd0));          // zero prefix, empty
      stimulus.push_back(make_req(OP_ADD, ent_a, 8'd0));
      stimulus.push_back(make_req(OP_LOOKUP, ent_a_alias, 8'd0));   // same after normalizing
      stimulus.push_back(make_req(OP_ADD, ent_a_alias, 8'd0));      // duplicate, refused
      stimulus.push_back(make_req(OP_ADD_UNCHECKED, ent_a, 8'd0));  // duplicate stored anyway
      stimulus.push_back(make_req(OP_DELETE, ent_a, 8'd0));         // removes first copy only
      stimulus.push_back(make_req(OP_ADD, ent_b, 8'd0));
      stimulus.push_back(make_req(OP_ADD, ent_c, 8'd0));
      e = ent_b;
      e.ifindex = 32'd7;
      stimulus.push_back(make_req(OP_LOOKUP, e, 8'd0));             // ifindex differs: miss
      e = random_entry();
      e.family_is_v6 = 1'b0;
      stimulus.push_back(make_req(OP_QUERY, e, 8'd0));              // zero prefix hits all v4
      e = ent_a;
      e.addr_low[0] = 1'b0;
      stimulus.push_back(make_req(OP_QUERY, e, 8'd32));             // host bit differs: miss
      stimulus.push_back(make_req(OP_QUERY, e, 8'd31));             // masked off: hit
      stimulus.push_back(make_req(OP_QUERY, ent_a, 8'd200));        // long prefix clamps to 32
      e = ent_b;
      e.addr_low = 64'd0;
      stimulus.push_back(make_req(OP_QUERY, e, 8'd64));             // only upper half compared
      stimulus.push_back(make_req(OP_QUERY, e, 8'd65));             // first lower bit differs
      e = ent_c;
      e.ifindex = 32'd5;
      stimulus.push_back(make_req(OP_QUERY, e, 8'd255));            // ifindex ignored, clamp
      e.addr_low = 64'd1;
      stimulus.push_back(make_req(OP_QUERY, e, 8'd128));            // last bit differs
      stimulus.push_back(make_req(OP_UNUSED_6, ent_b, 8'hff));
      stimulus.push_back(make_req(OP_UNUSED_7, ent_c, 8'h80));
      stimulus.push_back(make_req(OP_DELETE, ent_a_alias, 8'd0));   // delete head
      stimulus.push_back(make_req(OP_DELETE, ent_a, 8'd0));         // now missing
      stimulus.push_back(make_req(OP_ADD, ent_a, 8'd0));            // order is b, c, a
      stimulus.push_back(make_req(OP_DELETE, ent_c, 8'd0));         // middle, a shifts down
      stimulus.push_back(make_req(OP_LOOKUP, ent_a, 8'd0));
      stimulus.push_back(make_req(OP_PURGE, ent_b, 8'd0));
      stimulus.push_back(make_req(OP_LOOKUP, ent_b, 8'd0));         // gone after purge
      directed_total = stimulus.size();

      // ---- random part ----
      // A small pool keeps lookups, deletes and duplicate adds landing on stored entries;
      // some neighbors differ only in ifindex.
      for (int i = 0; i < POOL_SIZE; i++) begin
         pool[i] = random_entry();
         if (i > 0 && $urandom_range(0, 2) == 0) begin
            pool[i] = pool[i - 1];
            pool[i].ifindex = $urandom;
         end
      end

      while (stimulus.size() < ITEM_TOTAL) begin
         if ($urandom_range(0, 7) == 0) begin
            // fill episode: purge, overfill with fresh entries, then poke the full table
            stimulus.push_back(make_req(OP_PURGE, random_entry(), 8'($urandom)));
            for (int k = 0; k < FILL_ADDS; k++) begin
               fresh[k] = random_entry();
               op = $urandom_range(0, 1) ? OP_ADD : OP_ADD_UNCHECKED;
               stimulus.push_back(make_req(op, fresh[k], 8'($urandom)));
            end
            stimulus.push_back(make_req(OP_ADD, fresh[3], 8'd0));           // dup on full
            stimulus.push_back(make_req(OP_ADD_UNCHECKED, fresh[3], 8'd0)); // refused
            stimulus.push_back(make_req(OP_QUERY, fresh[9], 8'd0));
            stimulus.push_back(make_req(OP_DELETE, fresh[5], 8'd0));
            stimulus.push_back(make_req(OP_DELETE, fresh[0], 8'd0));
            stimulus.push_back(make_req(OP_DELETE, fresh[SET_DEPTH - 1], 8'd0));
            stimulus.push_back(make_req(OP_LOOKUP, fresh[FILL_ADDS - 1], 8'd0)); // never stored
         end else begin
            e = pool[$urandom_range(0, POOL_SIZE - 1)];
            if ($urandom_range(0, 9) == 0) e = random_entry();
            // junk upper bits on IPv4 requests
            if (!e.family_is_v6 && $urandom_range(0, 1)) begin
               e.addr_high        = {$urandom, $urandom};
               e.addr_low[63:32]  = $urandom;
            end
            roll = $urandom_range(0, 99);
            if (roll < 15)      op = OP_LOOKUP;
            else if (roll < 45) op = OP_ADD;
            else if (roll < 60) op = OP_ADD_UNCHECKED;
            else if (roll < 80) op = OP_DELETE;
            else if (roll < 95) op = OP_QUERY;
            else if (roll < 97) op = OP_PURGE;
            else                op = roll[0] ? OP_UNUSED_6 : OP_UNUSED_7;
            plen = 8'($urandom);
            if (op == OP_QUERY) begin
               if ($urandom_range(0, 3) != 0)
                  plen = e.family_is_v6 ? 8'($urandom_range(0, 128))
                                        : 8'($urandom_range(0, 32));
               // flip one bit so the prefix decides hit or miss
               if ($urandom_range(0, 1)) begin
                  pos  = e.family_is_v6 ? $urandom_range(0, 127) : $urandom_range(0, 31);
                  flat = {e.addr_high, e.addr_low};
                  flat[pos] = ~flat[pos];
                  {e.addr_high, e.addr_low} = flat;
               end
            end
            stimulus.push_back(make_req(op, e, plen));
         end
      end

      // ---- drive ----
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int n = 0; n < stimulus.size(); n++) begin
         // idling comes in segments, and never in the tail
         idle_on = (n < stimulus.size() - CALM_TAIL) && ((n / 150) % 3 != 2);
         if (n == directed_total + 400) long_hold_due = 1'b1;
         if (idle_on && $urandom_range(0, 4) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_data  <= stimulus[n];
         do @(posedge clock); while (req_stall);
      end
      req_valid <= 1'b0;
      @(posedge clock);

      // let outstanding results drain, then watch for strays
      wait (pending_count == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d request transfers (%0d directed) and scored %0d results.",
               stimulus.size(), directed_total, result_count);
      $display("Of those, %0d hits and %0d refusals on a full table.", hit_count, full_count);
      if (fail_count == 0) begin
         $display("ip_address_set_table test passed");
      end else begin
         $display("ip_address_set_table test failed");
      end
      $finish;
   end

   // Receiver: random stall bursts, plus one long hold-off that backs up the input side.
   initial begin
      int len;
      bit hold_now;
      forever begin
         @(posedge clock);
         if (long_hold_due && !long_hold_done) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD - 1) @(posedge clock);
            long_hold_done = 1'b1;
         end else begin
            hold_now = idle_on && ($urandom_range(0, 3) == 0);
            rsp_stall <= hold_now;
            len = hold_now ? $urandom_range(1, 6) : $urandom_range(1, 10);
            repeat (len - 1) @(posedge clock);
         end
      end
   end

   // Watchdog: several times the slowest legal run.
   initial begin
      #8_000_000;
      $display("ip_address_set_table test failed");
      $finish;
   end

endmodule
